[design/jfd_pkg.sv]
// shared types and constants of the joystick frame decoder
package jfd_pkg;

	// characters of the frame syntax
	localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
	localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
	localparam logic [7:0] CHAR_COMMA    = 8'h2C;
	localparam logic [7:0] CHAR_PLUS     = 8'h2B;
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_NINE     = 8'h39;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_NUL      = 8'h00;

	// tag text "joystick"
	localparam logic [3:0] TAG_LEN = 4'd8;

	// configuration register indexes
	localparam logic [1:0] REG_SPEED_GAIN = 2'd0;
	localparam logic [1:0] REG_TURN_GAIN  = 2'd1;
	localparam logic [1:0] REG_DEAD_ZONE  = 2'd2;

	// reset values of the configuration registers
	localparam logic [7:0] SPEED_GAIN_RST = 8'd8;
	localparam logic [7:0] TURN_GAIN_RST  = 8'd32;
	localparam logic [6:0] DEAD_ZONE_RST  = 7'd5;

	// closed frame with its two raw fields
	typedef struct packed {
		logic       valid;
		logic [7:0] lv;
		logic [7:0] rh;
	} frame_evt_t;

	// character of the tag at a given position
	function automatic logic [7:0] tag_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h6A; // j
			3'd1: c = 8'h6F; // o
			3'd2: c = 8'h79; // y
			3'd3: c = 8'h73; // s
			3'd4: c = 8'h74; // t
			3'd5: c = 8'h69; // i
			3'd6: c = 8'h63; // c
			default: c = 8'h6B; // k
		endcase
		return c;
	endfunction

endpackage

[design/jfd_parser.sv]
// byte-wise frame parser: tag check, token count and the two number fields
module jfd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_en,
	input  logic [7:0]         byte_data,
	output jfd_pkg::frame_evt_t evt
);

	// number conversion phases
	localparam logic [1:0] PH_SPACE  = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_STOP   = 2'd2;

	logic       in_frame_q, in_frame_d;
	logic [2:0] token_index_q, token_index_d;
	logic       token_open_q, token_open_d;
	logic [3:0] tag_position_q, tag_position_d;
	logic       tag_mismatch_q, tag_mismatch_d;
	logic [1:0] number_phase_q, number_phase_d;
	logic       number_negative_q, number_negative_d;
	logic [7:0] number_acc_q, number_acc_d;
	logic [7:0] held_speed_q, held_speed_d;
	logic       nul_seen_q, nul_seen_d;

	logic       do_close;
	logic [2:0] tok_n;
	logic [7:0] fin_val;
	logic       is_space;
	logic       is_digit;
	logic       num_skip;

	always_comb begin
		in_frame_d        = in_frame_q;
		token_index_d     = token_index_q;
		token_open_d      = token_open_q;
		tag_position_d    = tag_position_q;
		tag_mismatch_d    = tag_mismatch_q;
		number_phase_d    = number_phase_q;
		number_negative_d = number_negative_q;
		number_acc_d      = number_acc_q;
		held_speed_d      = held_speed_q;
		nul_seen_d        = nul_seen_q;
		evt               = '0;
		do_close          = 1'b0;
		num_skip          = 1'b0;
		is_space = (byte_data == jfd_pkg::CHAR_SPACE) || (byte_data inside {[8'd9:8'd13]});
		is_digit = (byte_data >= jfd_pkg::CHAR_ZERO) && (byte_data <= jfd_pkg::CHAR_NINE);
		fin_val  = number_negative_q ? 8'(8'd0 - number_acc_q) : number_acc_q;
		tok_n    = token_index_q - 3'd1;

		if (byte_en) begin
			if (!in_frame_q) begin
				// wait for an opening bracket
				if (byte_data == jfd_pkg::CHAR_LBRACKET) begin
					in_frame_d        = 1'b1;
					token_index_d     = '0;
					token_open_d      = 1'b0;
					tag_position_d    = '0;
					tag_mismatch_d    = 1'b0;
					number_phase_d    = PH_SPACE;
					number_negative_d = 1'b0;
					number_acc_d      = '0;
					held_speed_d      = '0;
					nul_seen_d        = 1'b0;
				end
			end else if (byte_data == jfd_pkg::CHAR_RBRACKET) begin
				do_close   = 1'b1;
				in_frame_d = 1'b0;
			end else if (!nul_seen_q) begin
				if (byte_data == jfd_pkg::CHAR_NUL) begin
					do_close   = 1'b1;
					nul_seen_d = 1'b1;
				end else if (byte_data == jfd_pkg::CHAR_COMMA) begin
					do_close = 1'b1;
				end else begin
					// start a new token on its first character
					if (!token_open_q) begin
						token_open_d = 1'b1;
						if (token_index_q != 3'd7)
							token_index_d = token_index_q + 3'd1;
						if (token_index_d == 3'd3 || token_index_d == 3'd4) begin
							number_phase_d    = PH_SPACE;
							number_negative_d = 1'b0;
							number_acc_d      = '0;
						end
					end
					tok_n = token_index_d - 3'd1;
					if (tok_n == 3'd0) begin
						// tag compare
						if (tag_position_q < jfd_pkg::TAG_LEN &&
							byte_data == jfd_pkg::tag_char(tag_position_q[2:0]))
							tag_position_d = tag_position_q + 4'd1;
						else
							tag_mismatch_d = 1'b1;
					end else if (tok_n == 3'd2 || tok_n == 3'd3) begin
						// atoi-like number conversion
						if (number_phase_d == PH_SPACE) begin
							if (is_space) begin
								num_skip = 1'b1;
							end else if (byte_data == jfd_pkg::CHAR_PLUS ||
								byte_data == jfd_pkg::CHAR_MINUS) begin
								number_negative_d = (byte_data == jfd_pkg::CHAR_MINUS);
								number_phase_d    = PH_DIGITS;
								num_skip          = 1'b1;
							end else begin
								number_phase_d = PH_DIGITS;
							end
						end
						if (!num_skip && number_phase_d == PH_DIGITS) begin
							if (is_digit)
								number_acc_d = 8'((number_acc_d << 3) + (number_acc_d << 1)
									+ (byte_data - jfd_pkg::CHAR_ZERO));
							else
								number_phase_d = PH_STOP;
						end
					end
				end
			end

			// token close: latch the finished field value
			if (do_close) begin
				if (token_open_q) begin
					if (tok_n == 3'd2) begin
						held_speed_d = fin_val;
					end else if (tok_n == 3'd3) begin
						number_acc_d      = fin_val;
						number_negative_d = 1'b0;
						number_phase_d    = PH_STOP;
					end
				end
				token_open_d = 1'b0;
			end

			// frame end with a good tag and enough tokens
			if (in_frame_q && byte_data == jfd_pkg::CHAR_RBRACKET) begin
				evt.valid = (token_index_q >= 3'd4) && !tag_mismatch_q &&
					(tag_position_q == jfd_pkg::TAG_LEN);
				evt.lv    = held_speed_d;
				evt.rh    = number_acc_d;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q        <= 1'b0;
			token_index_q     <= '0;
			token_open_q      <= 1'b0;
			tag_position_q    <= '0;
			tag_mismatch_q    <= 1'b0;
			number_phase_q    <= PH_SPACE;
			number_negative_q <= 1'b0;
			number_acc_q      <= '0;
			held_speed_q      <= '0;
			nul_seen_q        <= 1'b0;
		end else begin
			in_frame_q        <= in_frame_d;
			token_index_q     <= token_index_d;
			token_open_q      <= token_open_d;
			tag_position_q    <= tag_position_d;
			tag_mismatch_q    <= tag_mismatch_d;
			number_phase_q    <= number_phase_d;
			number_negative_q <= number_negative_d;
			number_acc_q      <= number_acc_d;
			held_speed_q      <= held_speed_d;
			nul_seen_q        <= nul_seen_d;
		end
	end

	// a result only comes from a closing bracket inside a frame
	a_evt_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> (byte_en && in_frame_q && byte_data == jfd_pkg::CHAR_RBRACKET))
		else $error("frame event without closing bracket");

	// tag position never runs past the tag length
	a_tag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tag_position_q <= jfd_pkg::TAG_LEN)
		else $error("tag position out of range");

endmodule

[design/joystick_frame_decoder_unit.sv]
// top level of the joystick frame decoder: parser, scaling stage, output register
//
//  channel   | dir | word                                        | handshake
//  s_axis    | in  | tdata[7:0] rx_byte                          | tvalid/tready
//  m_axis    | out | tdata[15:0] speed_target, [31:16] turn_cmd  | tvalid/tready
//  cfg       | in  | cfg_index, cfg_data                         | cfg_we, no wait
//
// one byte is taken every cycle while s_axis_tready is high; the parser state updates on the byte itself
// a result runs from the s1 event register to the output register, which drives m_axis_tvalid
// the s1 event register and the output register hold up to two results
// s_axis_tready drops only while s1 holds a result and the output is stalled
// arst_n clears the parser, the pipeline valids and the gains to their defaults
module joystick_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] speed_target, [31:16] turn_cmd
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                byte_acc;
	jfd_pkg::frame_evt_t evt;

	logic       valid_s1;
	logic [7:0] lv_s1;
	logic [7:0] rh_s1;

	logic       out_free;
	logic       adv_s1;
	logic       m_valid_q;
	logic [15:0] speed_q;
	logic [15:0] turn_q;

	logic [7:0] speed_gain_q;
	logic [7:0] turn_gain_q;
	logic [6:0] dead_zone_q;

	logic [7:0]  rh_mag;
	logic        in_dead;
	logic [15:0] spd_prod;
	logic [15:0] trn_prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q <= jfd_pkg::SPEED_GAIN_RST;
			turn_gain_q  <= jfd_pkg::TURN_GAIN_RST;
			dead_zone_q  <= jfd_pkg::DEAD_ZONE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				jfd_pkg::REG_SPEED_GAIN: speed_gain_q <= cfg_data;
				jfd_pkg::REG_TURN_GAIN:  turn_gain_q  <= cfg_data;
				jfd_pkg::REG_DEAD_ZONE:  dead_zone_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// handshake control
	assign out_free      = !m_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign byte_acc      = s_axis_tvalid && s_axis_tready;

	jfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_acc),
		.byte_data (s_axis_tdata),
		.evt       (evt)
	);

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_acc) begin
			valid_s1 <= evt.valid;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc && evt.valid) begin
			lv_s1 <= evt.lv;
			rh_s1 <= evt.rh;
		end
	end

	// scaling: signed field times unsigned gain, turn forced to zero in dead zone
	assign rh_mag   = rh_s1[7] ? 8'(8'd0 - rh_s1) : rh_s1;
	assign in_dead  = rh_mag < {1'b0, dead_zone_q};
	assign spd_prod = 16'($signed(lv_s1) * $signed({1'b0, speed_gain_q}));
	assign trn_prod = 16'($signed(rh_s1) * $signed({1'b0, turn_gain_q}));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			speed_q <= spd_prod;
			turn_q  <= in_dead ? 16'd0 : trn_prod;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {turn_q, speed_q};

	// a result inside the dead zone leaves with zero turn
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && in_dead) |=> (m_axis_tdata[31:16] == 16'd0))
		else $error("turn not zero inside dead zone");

	// a held s1 result is not dropped while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1)
		else $error("s1 result lost under stall");

	// input side stalls only when both stages are occupied
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_valid_q))
		else $error("input stalled without full pipeline");

	// an advancing s1 result always shows up on the output
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> m_axis_tvalid)
		else $error("advanced result missing on output");

endmodule
